### rtl/mcvc_pkg.sv
// ----------------------------------------------------------------------------
// mcvc_pkg
// shared widths, constants and the saturating cost adder of the volume cover
// ----------------------------------------------------------------------------
package mcvc_pkg;

  localparam int PRICE_W = 14;
  localparam int VOL_W   = 14;
  localparam int TGT_W   = 14;
  localparam int COST_W  = 32;
  localparam int KOUT_W  = 8;

  localparam logic [COST_W-1:0] COST_TOP = {COST_W{1'b1}};

  // cost add that sticks at all ones
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [PRICE_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {{(COST_W+1-PRICE_W){1'b0}}, b};
    return s[COST_W] ? COST_TOP : s[COST_W-1:0];
  endfunction

endpackage

### rtl/min_cost_volume_cover_dp_core.sv
// ----------------------------------------------------------------------------
// min_cost_volume_cover_dp_core
// cheapest cover of a target volume by unbounded purchase of loaded kinds
// ----------------------------------------------------------------------------
// Kinds load one per cycle while busy is low. A word with in_last_kind set
// starts the solve: busy rises and the block walks its cost row, which lives
// in a single-port-write ram and is updated one volume entry per cycle. The
// first kind worked (the last loaded) fills entries 1 to t of the row, every
// other kind touches each of the t entries once, after the states S_KFETCH
// and S_KLOAD fetch it from the kind ram. A zero target gives its result in
// the cycle after the last word with no busy time. The result shows for one
// cycle on out_valid and cannot be held off by the receiver.
module min_cost_volume_cover_dp_core #(
  parameter int MAX_KINDS  = 128,
  parameter int MAX_TARGET = 16383
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [mcvc_pkg::PRICE_W-1:0] in_kind_price,
  input  logic [mcvc_pkg::VOL_W-1:0]  in_kind_volume,
  input  logic                        in_last_kind,
  input  logic                        cfg_wr_en,
  input  logic [mcvc_pkg::TGT_W-1:0]  cfg_wr_data,
  output logic                        out_valid,
  output logic [mcvc_pkg::COST_W-1:0] out_min_cost,
  output logic [mcvc_pkg::KOUT_W-1:0] out_kinds_used
);

  import mcvc_pkg::*;

  localparam int KIDX_W = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;
  localparam int LC_W   = $clog2(MAX_KINDS + 1);
  localparam int CNT_W  = $clog2(MAX_KINDS + 1);
  localparam int TW     = $clog2(MAX_TARGET + 1);
  localparam int SUM_W  = ((TW > VOL_W) ? TW : VOL_W) + 1;
  localparam int RW     = COST_W + CNT_W;
  localparam int KW     = PRICE_W + VOL_W;

  typedef enum logic [2:0] {
    S_IDLE, S_KFETCH, S_KLOAD, S_INIT, S_RUN, S_DRAIN, S_RDRES, S_RESULT
  } state_t;

  state_t                state_r, state_nxt;
  logic [TGT_W-1:0]      cfg_target_r;
  logic [LC_W-1:0]       loaded_r, loaded_nxt;
  logic [KIDX_W-1:0]     cursor_r, cursor_nxt;
  logic                  init_first_r, init_first_nxt;
  logic [TW-1:0]         t_r, t_nxt;
  logic [PRICE_W-1:0]    p_r, p_nxt;
  logic [VOL_W-1:0]      v_r, v_nxt;
  logic [TW-1:0]         k_r, k_nxt;
  logic [TW-1:0]         r_r, r_nxt;
  logic [VOL_W-1:0]      pos_r, pos_nxt;
  logic [COST_W-1:0]     icost_r, icost_nxt;
  logic                  chain_first_r, chain_first_nxt;
  logic                  b_valid_r, b_valid_nxt;
  logic [TW-1:0]         b_addr_r, b_addr_nxt;
  logic                  b_first_r, b_first_nxt;
  logic [COST_W-1:0]     g_cost_r, g_cost_nxt;
  logic [CNT_W-1:0]      g_cnt_r, g_cnt_nxt;
  logic [COST_W-1:0]     po_cost_r, po_cost_nxt;
  logic [CNT_W-1:0]      po_cnt_r, po_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COST_W-1:0]     out_cost_r, out_cost_nxt;
  logic [KOUT_W-1:0]     out_kinds_r, out_kinds_nxt;

  // memory ports
  logic                  kram_we;
  logic [KW-1:0]         kram_wdata, kram_rdata;
  logic                  row_we;
  logic [TW-1:0]         row_waddr, row_raddr;
  logic [RW-1:0]         row_wdata, row_rdata;

  // stage b datapath
  logic [COST_W-1:0]     old_cost, one_cost, more_cost, gn_cost;
  logic [CNT_W-1:0]      old_cnt, one_cnt, gn_cnt;
  logic                  take_g;

  logic [TW-1:0]         t_sat;
  logic [VOL_W-1:0]      vol_fix;
  logic [LC_W-1:0]       n_kinds;
  logic [SUM_W-1:0]      ksum, rnext;
  logic                  init_we;

  assign t_sat   = (cfg_target_r > MAX_TARGET) ? TW'(MAX_TARGET) : TW'(cfg_target_r);
  assign vol_fix = (in_kind_volume == '0) ? VOL_W'(1) : in_kind_volume;
  assign ksum    = SUM_W'(k_r) + SUM_W'(v_r);
  assign rnext   = SUM_W'(r_r) + SUM_W'(1);

  mcvc_ram #(.WIDTH(KW), .DEPTH(MAX_KINDS)) u_kind_ram (
    .clk   (clk),
    .we    (kram_we),
    .waddr (loaded_r[KIDX_W-1:0]),
    .wdata (kram_wdata),
    .raddr (cursor_r),
    .rdata (kram_rdata)
  );

  mcvc_ram #(.WIDTH(RW), .DEPTH(MAX_TARGET + 1)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // stage b: extend the chain and merge with the stored entry
  always_comb begin
    old_cost  = row_rdata[RW-1:CNT_W];
    old_cnt   = row_rdata[CNT_W-1:0];
    one_cost  = sat_add(po_cost_r, p_r);
    one_cnt   = po_cnt_r + CNT_W'(1);
    more_cost = sat_add(g_cost_r, p_r);
    if (b_first_r) begin
      gn_cost = COST_W'(p_r);
      gn_cnt  = CNT_W'(1);
    end else if (more_cost < one_cost || (more_cost == one_cost && g_cnt_r > one_cnt)) begin
      gn_cost = more_cost;
      gn_cnt  = g_cnt_r;
    end else begin
      gn_cost = one_cost;
      gn_cnt  = one_cnt;
    end
    take_g = (gn_cost < old_cost) || (gn_cost == old_cost && gn_cnt > old_cnt);
  end

  assign init_we   = (state_r == S_INIT);
  assign row_we    = init_we || b_valid_r;
  assign row_waddr = init_we ? k_r : b_addr_r;
  assign row_wdata = init_we ? {icost_r, CNT_W'(1)} :
                     (take_g ? {gn_cost, gn_cnt} : {old_cost, old_cnt});
  assign row_raddr = (state_r == S_RDRES) ? t_r : k_r;
  assign kram_wdata = {in_kind_price, vol_fix};

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    loaded_nxt      = loaded_r;
    cursor_nxt      = cursor_r;
    init_first_nxt  = init_first_r;
    t_nxt           = t_r;
    p_nxt           = p_r;
    v_nxt           = v_r;
    k_nxt           = k_r;
    r_nxt           = r_r;
    pos_nxt         = pos_r;
    icost_nxt       = icost_r;
    chain_first_nxt = chain_first_r;
    b_valid_nxt     = 1'b0;
    b_addr_nxt      = k_r;
    b_first_nxt     = chain_first_r;
    g_cost_nxt      = b_valid_r ? gn_cost : g_cost_r;
    g_cnt_nxt       = b_valid_r ? gn_cnt : g_cnt_r;
    po_cost_nxt     = b_valid_r ? old_cost : po_cost_r;
    po_cnt_nxt      = b_valid_r ? old_cnt : po_cnt_r;
    out_valid_nxt   = 1'b0;
    out_cost_nxt    = out_cost_r;
    out_kinds_nxt   = out_kinds_r;
    kram_we         = 1'b0;
    n_kinds         = loaded_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (loaded_r < LC_W'(MAX_KINDS)) begin
            kram_we    = 1'b1;
            loaded_nxt = loaded_r + LC_W'(1);
          end
          n_kinds = loaded_nxt;
          if (in_last_kind) begin
            loaded_nxt = '0;
            t_nxt      = t_sat;
            if (t_sat == '0) begin
              out_valid_nxt = 1'b1;
              out_cost_nxt  = '0;
              out_kinds_nxt = '0;
            end else begin
              cursor_nxt     = KIDX_W'(n_kinds - LC_W'(1));
              init_first_nxt = 1'b1;
              state_nxt      = S_KFETCH;
            end
          end
        end
      end
      S_KFETCH: begin
        state_nxt = S_KLOAD;
      end
      S_KLOAD: begin
        p_nxt = kram_rdata[KW-1:VOL_W];
        v_nxt = kram_rdata[VOL_W-1:0];
        k_nxt = TW'(1);
        if (init_first_r) begin
          icost_nxt = COST_W'(kram_rdata[KW-1:VOL_W]);
          pos_nxt   = VOL_W'(1);
          state_nxt = S_INIT;
        end else begin
          r_nxt           = TW'(1);
          chain_first_nxt = 1'b1;
          state_nxt       = S_RUN;
        end
      end
      S_INIT: begin
        // ceil(k / v) units of the first kind, by running count
        if (k_r == t_r) begin
          init_first_nxt = 1'b0;
          if (cursor_r == '0) begin
            state_nxt = S_DRAIN;
          end else begin
            cursor_nxt = cursor_r - KIDX_W'(1);
            state_nxt  = S_KFETCH;
          end
        end else begin
          k_nxt = k_r + TW'(1);
          if (pos_r == v_r) begin
            pos_nxt   = VOL_W'(1);
            icost_nxt = sat_add(icost_r, p_r);
          end else begin
            pos_nxt = pos_r + VOL_W'(1);
          end
        end
      end
      S_RUN: begin
        // issue one row read per cycle along residue chains
        b_valid_nxt     = 1'b1;
        chain_first_nxt = 1'b0;
        if (ksum <= SUM_W'(t_r)) begin
          k_nxt = ksum[TW-1:0];
        end else if (rnext <= SUM_W'(v_r) && rnext <= SUM_W'(t_r)) begin
          r_nxt           = rnext[TW-1:0];
          k_nxt           = rnext[TW-1:0];
          chain_first_nxt = 1'b1;
        end else if (cursor_r == '0) begin
          state_nxt = S_DRAIN;
        end else begin
          cursor_nxt = cursor_r - KIDX_W'(1);
          state_nxt  = S_KFETCH;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RDRES;
      end
      S_RDRES: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        out_valid_nxt = 1'b1;
        out_cost_nxt  = row_rdata[RW-1:CNT_W];
        out_kinds_nxt = (32'(row_rdata[CNT_W-1:0]) > 32'd255) ? {KOUT_W{1'b1}} :
                        KOUT_W'(row_rdata[CNT_W-1:0]);
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cfg_target_r  <= '0;
      loaded_r      <= '0;
      cursor_r      <= '0;
      init_first_r  <= 1'b0;
      b_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_wr_en) begin
        cfg_target_r <= cfg_wr_data;
      end
      loaded_r      <= loaded_nxt;
      cursor_r      <= cursor_nxt;
      init_first_r  <= init_first_nxt;
      b_valid_r     <= b_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    t_r           <= t_nxt;
    p_r           <= p_nxt;
    v_r           <= v_nxt;
    k_r           <= k_nxt;
    r_r           <= r_nxt;
    pos_r         <= pos_nxt;
    icost_r       <= icost_nxt;
    chain_first_r <= chain_first_nxt;
    b_addr_r      <= b_addr_nxt;
    b_first_r     <= b_first_nxt;
    g_cost_r      <= g_cost_nxt;
    g_cnt_r       <= g_cnt_nxt;
    po_cost_r     <= po_cost_nxt;
    po_cnt_r      <= po_cnt_nxt;
    out_cost_r    <= out_cost_nxt;
    out_kinds_r   <= out_kinds_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_min_cost   = out_cost_r;
  assign out_kinds_used = out_kinds_r;

  // checks
  a_stage_b_window: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (state_r == S_RUN || state_r == S_KFETCH || state_r == S_DRAIN))
    else $error("row update outside a kind pass");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(init_we && b_valid_r))
    else $error("row fill and row update collide");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= LC_W'(MAX_KINDS))
    else $error("load count beyond store depth");

  a_result_ends_solve: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT) |=> (out_valid_r && !busy))
    else $error("result word not issued at end of solve");

endmodule

### rtl/mcvc_ram.sv
// ----------------------------------------------------------------------------
// mcvc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mcvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### test/mcvc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcvc_checker
// watches the kind and result channels of the volume cover core and predicts
// every result from its own copy of the kind store and the target register
// ----------------------------------------------------------------------------
module mcvc_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [mcvc_pkg::PRICE_W-1:0] in_kind_price,
  input  logic [mcvc_pkg::VOL_W-1:0]   in_kind_volume,
  input  logic                         in_last_kind,
  input  logic                         cfg_wr_en,
  input  logic [mcvc_pkg::TGT_W-1:0]   cfg_wr_data,
  input  logic                         out_valid,
  input  logic [mcvc_pkg::COST_W-1:0]  out_min_cost,
  input  logic [mcvc_pkg::KOUT_W-1:0]  out_kinds_used,
  output int                           errors,
  output int                           pending
);
  import mcvc_pkg::*;

  localparam int NKINDS = 128;
  localparam int TMAX   = 16383;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [15:0]       cnt;
  } cover_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [KOUT_W-1:0] kinds;
  } cover_word_t;

  logic [PRICE_W-1:0] kind_price_q [NKINDS];
  logic [VOL_W-1:0]   kind_vol_q   [NKINDS];
  int                 kinds_held;
  logic [TGT_W-1:0]   target_q;
  cover_t             cover_row [TMAX+1];
  cover_word_t        cover_expected [$];

  function automatic logic [COST_W-1:0] cost_add(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_TOP : s[COST_W-1:0];
  endfunction

  // cheaper wins, a tie goes to more kinds
  function automatic cover_t cheaper(cover_t a, cover_t b);
    if (b.cost < a.cost || (b.cost == a.cost && b.cnt > a.cnt)) return b;
    return a;
  endfunction

  function automatic cover_t cheapest_cover(int n, int t);
    cover_t none;
    cover_t g, prev, one, more, old;
    longint unsigned units, c;
    int p, v, cur;
    none = '0;
    if (t == 0 || n == 0) return none;
    // last loaded kind fills the whole row
    p = kind_price_q[n-1];
    v = kind_vol_q[n-1];
    for (int k = 1; k <= t; k++) begin
      units = (longint'(k) + v - 1) / v;
      c = units * p;
      cover_row[k].cost = (c > 64'hFFFF_FFFF) ? COST_TOP : c[31:0];
      cover_row[k].cnt  = 1;
    end
    // remaining kinds, last to first, per residue chain
    for (cur = n - 2; cur >= 0; cur--) begin
      p = kind_price_q[cur];
      v = kind_vol_q[cur];
      for (int r = 1; r <= v && r <= t; r++) begin
        g.cost = p;
        g.cnt  = 1;
        prev = cover_row[r];
        cover_row[r] = cheaper(prev, g);
        for (int k = r + v; k <= t; k += v) begin
          one.cost  = cost_add(prev.cost, p);
          one.cnt   = prev.cnt + 16'd1;
          more.cost = cost_add(g.cost, p);
          more.cnt  = g.cnt;
          g = cheaper(one, more);
          old = cover_row[k];
          cover_row[k] = cheaper(old, g);
          prev = old;
        end
      end
    end
    return cover_row[t];
  endfunction

  assign pending = cover_expected.size();

  always @(posedge clk) begin
    cover_t      res;
    cover_word_t exp_w;
    if (!rst_n) begin
      kinds_held <= 0;
      target_q   <= '0;
      errors     <= 0;
      cover_expected.delete();
    end else begin
      // result side
      if (out_valid) begin
        if (cover_expected.size() == 0) begin
          $display("%0t: unexpected result cost %0d kinds %0d", $time,
                   out_min_cost, out_kinds_used);
          errors <= errors + 1;
        end else begin
          exp_w = cover_expected.pop_front();
          if (exp_w.cost !== out_min_cost || exp_w.kinds !== out_kinds_used) begin
            $display("%0t: mismatch expected cost %0d kinds %0d, got cost %0d kinds %0d",
                     $time, exp_w.cost, exp_w.kinds, out_min_cost, out_kinds_used);
            errors <= errors + 1;
          end
        end
      end
      // target register
      if (cfg_wr_en) target_q <= cfg_wr_data;
      // kind side
      if (start && !busy) begin
        int held;
        held = kinds_held;
        if (held < NKINDS) begin
          kind_price_q[held] = in_kind_price;
          kind_vol_q[held]   = (in_kind_volume == 0) ? VOL_W'(1) : in_kind_volume;
          held++;
        end
        if (in_last_kind) begin
          res = cheapest_cover(held, target_q);
          exp_w.cost  = res.cost;
          exp_w.kinds = (res.cnt > 255) ? 8'd255 : res.cnt[7:0];
          cover_expected.push_back(exp_w);
          held = 0;
        end
        kinds_held <= held;
      end
    end
  end

endmodule

### test/tb_min_cost_volume_cover_dp_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_min_cost_volume_cover_dp_core
// drives kind sets and target settings into the volume cover core; the
// checker beside it predicts each cheapest cover and compares the results
// ----------------------------------------------------------------------------
module tb_min_cost_volume_cover_dp_core;
  import mcvc_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [PRICE_W-1:0]  in_kind_price = '0;
  logic [VOL_W-1:0]    in_kind_volume = '0;
  logic                in_last_kind = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [TGT_W-1:0]    cfg_wr_data = '0;
  logic                out_valid;
  logic [COST_W-1:0]   out_min_cost;
  logic [KOUT_W-1:0]   out_kinds_used;
  int                  errors;
  int                  pending;
  int                  words_sent = 0;
  int                  sets_sent = 0;
  longint              cycles = 0;

  always #1 clk = ~clk;

  min_cost_volume_cover_dp_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind_price(in_kind_price), .in_kind_volume(in_kind_volume),
    .in_last_kind(in_last_kind), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_min_cost(out_min_cost), .out_kinds_used(out_kinds_used)
  );

  mcvc_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind_price(in_kind_price), .in_kind_volume(in_kind_volume),
    .in_last_kind(in_last_kind), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_min_cost(out_min_cost), .out_kinds_used(out_kinds_used),
    .errors(errors), .pending(pending)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one kind word, held until accepted
  task automatic send_kind(int price, int vol, bit last, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind_price  <= PRICE_W'(price);
    in_kind_volume <= VOL_W'(vol);
    in_last_kind   <= last;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    words_sent++;
    if (last) sets_sent++;
  endtask

  // wait for the core to drain, then change the target
  task automatic set_target(int t);
    start <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (8) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= TGT_W'(t);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // one random set of kinds sized for the current target
  task automatic random_set(int nk, int vmax, bit bursty);
    int p, v, gap;
    for (int i = 0; i < nk; i++) begin
      p   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 20);
      v   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, vmax);
      gap = bursty ? 0 : $urandom_range(0, 16);
      send_kind(p, v, i == nk - 1, gap);
    end
  endtask

  initial begin
    int t, phase_words;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero target with field extremes
    send_kind(16383, 16383, 1'b0, 0);
    send_kind(0, 0, 1'b0, 0);
    send_kind(1, 1, 1'b1, 0);
    send_kind(5, 3, 1'b1, 3);

    // small target, ties and zero volume
    set_target(7);
    send_kind(4, 2, 1'b0, 0);
    send_kind(2, 1, 1'b0, 0);
    send_kind(6, 3, 1'b0, 0);
    send_kind(8, 4, 1'b1, 0);
    send_kind(0, 0, 1'b0, 2);
    send_kind(3, 7, 1'b1, 0);
    send_kind(9, 16383, 1'b1, 0);

    // largest target, few kinds
    set_target(16383);
    send_kind(16383, 1, 1'b1, 0);
    send_kind(16383, 16383, 1'b0, 0);
    send_kind(1, 5461, 1'b1, 0);

    // random phases over several targets
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       t = 0;
        1:       t = 1;
        2:       t = 2;
        default: t = $urandom_range(3, 60);
      endcase
      set_target(t);
      phase_words = 0;
      while (phase_words < 50) begin
        int nk;
        nk = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 7);
        random_set(nk, t + 2, $urandom_range(0, 3) == 0);
        phase_words += nk;
      end
    end

    // store overflow: more kinds than the store holds
    set_target(4);
    random_set(131, 6, 1'b1);
    random_set(129, 6, 1'b0);
    set_target(1);
    random_set(140, 3, 1'b1);

    start <= 1'b0;
    wait (pending == 0);
    repeat (50) @(negedge clk);
    $display("covered %0d kind words in %0d sets over targets 0..16383,", words_sent, sets_sent);
    $display("including zero volumes, ties and store overflow");
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
